FILE: rtl/core/shc_pkg.sv
// shared types, codes and defaults for the sensor health classifier
`default_nettype none
package shc_pkg;

   // default sizing
   localparam int DevicesDef   = 16;
   localparam int DeadLimitDef = 10;

   // field widths
   localparam int WordW  = 16;
   localparam int CountW = 4;
   localparam int DevW   = 4;
   localparam int CsrIdxW = 3;
   localparam int ReqDataW = 72;
   localparam int RspDataW = 24;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrGasLimit  = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrGasBand   = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrHighLimit = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrLowLimit  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrTempBand  = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrPowerMin  = 3'd5;

   // register reset values
   localparam logic [WordW-1:0] GasLimitRst  = 16'd1000;
   localparam logic [WordW-1:0] GasBandRst   = 16'd50;
   localparam logic [WordW-1:0] HighLimitRst = 16'd350;
   localparam logic [WordW-1:0] LowLimitRst  = 16'd100;
   localparam logic [WordW-1:0] TempBandRst  = 16'd10;
   localparam logic [WordW-1:0] PowerMinRst  = 16'h02A0;

   // main status codes
   localparam logic [1:0] MainUnused = 2'd0;
   localparam logic [1:0] MainGood   = 2'd1;
   localparam logic [1:0] MainError  = 2'd2;

   // page status codes
   localparam logic [2:0] PageUnused  = 3'd0;
   localparam logic [2:0] PageGood    = 3'd1;
   localparam logic [2:0] PageCold    = 3'd2;
   localparam logic [2:0] PageHot     = 3'd3;
   localparam logic [2:0] PageNoPower = 3'd4;
   localparam logic [2:0] PageGas     = 3'd5;
   localparam logic [2:0] PageDead    = 3'd6;

   // link level codes
   localparam logic [1:0] LinkUnused = 2'd0;
   localparam logic [1:0] LinkGood   = 2'd1;
   localparam logic [1:0] LinkWeak   = 2'd2;
   localparam logic [1:0] LinkDead   = 2'd3;

   // link grading thresholds
   localparam logic [WordW-1:0] LinkDeadAbove = 16'd200;
   localparam logic [WordW-1:0] LinkWeakAbove = 16'd100;
   localparam logic [9:0]       LinkClamp     = 10'd999;

   // per-device state entry
   typedef struct packed {
      logic [CountW-1:0] dead_count;
      logic              link_fault;
      logic              gas_fault;
      logic              hot_fault;
      logic              cold_fault;
   } entry_type;

   // one sensor report
   typedef struct packed {
      logic [WordW-1:0] rssi_raw;
      logic [WordW-1:0] supply_level;
      logic [WordW-1:0] co2_level;
      logic [WordW-1:0] temperature;
      logic             enabled;
      logic [DevW-1:0]  device;
      logic             scan_start;
   } req_type;

   // one classification result
   typedef struct packed {
      logic       alarm_any;
      logic [9:0] link_display;
      logic [1:0] link_level;
      logic [2:0] page_code;
      logic [1:0] health_state;
   } rsp_type;

   // limit registers
   typedef struct packed {
      logic [WordW-1:0] gas_limit;
      logic [WordW-1:0] gas_band;
      logic [WordW-1:0] high_temp_limit;
      logic [WordW-1:0] low_temp_limit;
      logic [WordW-1:0] temp_band;
      logic [WordW-1:0] power_min;
   } cfg_type;

endpackage
`default_nettype wire

FILE: rtl/core/sensor_health_classifier.sv
// sensor health classifier top level: report pipeline, limit registers, output beat
// each report passes the write-back stage register, then the output register
// throughput: one report per cycle unless results stall, one state read and write a cycle
// forwarding from the write-back stage keeps back-to-back reports to one device exact
// reset is synchronous, clears the pipeline, the alarm flag and the memory valid bits
// limit registers return to their defaults at reset
`default_nettype none
module sensor_health_classifier #(
   parameter int DEVICES    = shc_pkg::DevicesDef,
   parameter int DEAD_LIMIT = shc_pkg::DeadLimitDef
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // report beat
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // scan_start, device, enabled, temperature, co2_level, supply_level, rssi_raw, zero pad
   input  wire logic [shc_pkg::ReqDataW-1:0]  req_tdata,
   // result beat
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // health_state, page_code, link_level, link_display, alarm_any, zero pad
   output logic [shc_pkg::RspDataW-1:0]       rsp_tdata,
   // register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [shc_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [shc_pkg::WordW-1:0]     csr_data
);

   localparam int AW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

   shc_pkg::cfg_type   cfg_ff;
   shc_pkg::req_type   req_in;
   shc_pkg::req_type   s1_req_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   shc_pkg::rsp_type   rsp_ff;
   logic               accum_ff, accum_in;
   logic               accum_nxt;
   logic               req_accept, s1_adv;
   shc_pkg::entry_type entry_cur, entry_nxt;
   shc_pkg::rsp_type   rsp_nxt;
   logic               cls_wr;

   // register writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gas_limit       <= shc_pkg::GasLimitRst;
         cfg_ff.gas_band        <= shc_pkg::GasBandRst;
         cfg_ff.high_temp_limit <= shc_pkg::HighLimitRst;
         cfg_ff.low_temp_limit  <= shc_pkg::LowLimitRst;
         cfg_ff.temp_band       <= shc_pkg::TempBandRst;
         cfg_ff.power_min       <= shc_pkg::PowerMinRst;
      end else if (csr_valid) begin
         unique case (csr_index)
            shc_pkg::CsrGasLimit:  cfg_ff.gas_limit       <= csr_data;
            shc_pkg::CsrGasBand:   cfg_ff.gas_band        <= csr_data;
            shc_pkg::CsrHighLimit: cfg_ff.high_temp_limit <= csr_data;
            shc_pkg::CsrLowLimit:  cfg_ff.low_temp_limit  <= csr_data;
            shc_pkg::CsrTempBand:  cfg_ff.temp_band       <= csr_data;
            shc_pkg::CsrPowerMin:  cfg_ff.power_min       <= csr_data;
            default: ;
         endcase
      end
   end

   // handshake and stage control
   assign req_in     = req_tdata[$bits(shc_pkg::req_type)-1:0];
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      accum_in = s1_adv ? accum_nxt : accum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         accum_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         accum_ff     <= accum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_nxt;
      end
   end

   // per-device state
   shc_state_mem #(
      .DEVICES (DEVICES),
      .AW      (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (AW'(req_in.device)),
      .rd_data (entry_cur),
      .wr_en   (s1_adv && cls_wr),
      .wr_addr (AW'(s1_req_ff.device)),
      .wr_data (entry_nxt)
   );

   // classification of the report in the write-back stage
   shc_classify #(
      .DEVICES    (DEVICES),
      .DEAD_LIMIT (DEAD_LIMIT)
   ) u_classify (
      .req       (s1_req_ff),
      .entry_cur (entry_cur),
      .cfg       (cfg_ff),
      .accum_cur (accum_ff),
      .wr_en     (cls_wr),
      .entry_nxt (entry_nxt),
      .accum_nxt (accum_nxt),
      .rsp       (rsp_nxt)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = shc_pkg::RspDataW'(rsp_ff);

endmodule
`default_nettype wire

FILE: rtl/core/shc_state_mem.sv
// per-device state memory with valid bits and write-to-read forwarding
`default_nettype none
module shc_state_mem #(
   parameter int DEVICES = shc_pkg::DevicesDef,
   parameter int AW      = (DEVICES > 1) ? $clog2(DEVICES) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output shc_pkg::entry_type       rd_data,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  shc_pkg::entry_type       wr_data
);

   shc_pkg::entry_type mem_ff [DEVICES];
   logic [DEVICES-1:0] valid_ff;
   logic [DEVICES-1:0] valid_in;
   shc_pkg::entry_type rd_ff;
   logic               rd_valid_ff;
   logic               fwd_hit_ff;
   shc_pkg::entry_type fwd_data_ff;

   // array write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // valid bits, an entry never written reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // read-side flags, forwarding covers a write in the read cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
            fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   assign rd_data = fwd_hit_ff  ? fwd_data_ff :
                    rd_valid_ff ? rd_ff       : '0;

endmodule
`default_nettype wire

FILE: rtl/core/shc_classify.sv
// report classification and per-device state update
`default_nettype none
module shc_classify #(
   parameter int DEVICES    = shc_pkg::DevicesDef,
   parameter int DEAD_LIMIT = shc_pkg::DeadLimitDef
) (
   input  shc_pkg::req_type   req,
   input  shc_pkg::entry_type entry_cur,
   input  shc_pkg::cfg_type   cfg,
   input  wire logic          accum_cur,
   output logic               wr_en,
   output shc_pkg::entry_type entry_nxt,
   output logic               accum_nxt,
   output shc_pkg::rsp_type   rsp
);

   localparam logic [shc_pkg::CountW-1:0] DeadLim = shc_pkg::CountW'(DEAD_LIMIT);

   logic                          active;
   logic                          accum_base;
   logic [shc_pkg::WordW-1:0]     strength;
   logic                          nopower;
   logic signed [shc_pkg::WordW+1:0] co2_s, temp_s;
   logic signed [shc_pkg::WordW+1:0] gas_hi, gas_lo, hot_set, hot_clr, cold_set, cold_clr;

   function automatic logic signed [shc_pkg::WordW+1:0] widen(input logic [shc_pkg::WordW-1:0] v);
      return $signed({2'b00, v});
   endfunction

   assign active     = req.enabled && (32'(req.device) < DEVICES);
   assign accum_base = req.scan_start ? 1'b0 : accum_cur;
   assign strength   = ~req.rssi_raw;

   // limits in signed wide form so a band never wraps
   assign co2_s    = widen(req.co2_level);
   assign temp_s   = widen(req.temperature);
   assign gas_hi   = widen(cfg.gas_limit) + widen(cfg.gas_band);
   assign gas_lo   = widen(cfg.gas_limit) - widen(cfg.gas_band);
   assign hot_set  = widen(cfg.high_temp_limit) + widen(cfg.temp_band);
   assign hot_clr  = widen(cfg.high_temp_limit);
   assign cold_set = widen(cfg.low_temp_limit) - widen(cfg.temp_band);
   assign cold_clr = widen(cfg.low_temp_limit);
   assign nopower  = req.supply_level < cfg.power_min;

   always_comb begin
      entry_nxt = entry_cur;
      rsp       = '0;
      accum_nxt = accum_base;
      wr_en     = active;

      if (active) begin
         // link grading
         if (strength > shc_pkg::LinkDeadAbove) begin
            rsp.link_level   = shc_pkg::LinkDead;
            rsp.link_display = shc_pkg::LinkClamp;
         end else if (strength > shc_pkg::LinkWeakAbove) begin
            rsp.link_level   = shc_pkg::LinkWeak;
            rsp.link_display = strength[9:0];
         end else begin
            rsp.link_level   = shc_pkg::LinkGood;
            rsp.link_display = strength[9:0];
         end

         // dead-link counter
         if (rsp.link_level == shc_pkg::LinkDead) begin
            if (entry_cur.dead_count < DeadLim) begin
               entry_nxt.dead_count = entry_cur.dead_count + 4'd1;
            end else begin
               entry_nxt.link_fault = 1'b1;
            end
         end else begin
            entry_nxt.dead_count = '0;
            entry_nxt.link_fault = 1'b0;
         end

         // gas hysteresis
         if (entry_cur.gas_fault) begin
            if (co2_s < gas_lo) entry_nxt.gas_fault = 1'b0;
         end else begin
            if (co2_s > gas_hi) entry_nxt.gas_fault = 1'b1;
         end

         // high temperature hysteresis
         if (entry_cur.hot_fault) begin
            if (temp_s < hot_clr) entry_nxt.hot_fault = 1'b0;
         end else begin
            if (temp_s > hot_set) entry_nxt.hot_fault = 1'b1;
         end

         // low temperature hysteresis
         if (entry_cur.cold_fault) begin
            if (temp_s > cold_clr) entry_nxt.cold_fault = 1'b0;
         end else begin
            if (temp_s < cold_set) entry_nxt.cold_fault = 1'b1;
         end

         // page code by priority
         rsp.health_state = shc_pkg::MainError;
         if (entry_nxt.link_fault) begin
            rsp.page_code = shc_pkg::PageDead;
         end else if (entry_nxt.gas_fault) begin
            rsp.page_code = shc_pkg::PageGas;
         end else if (nopower) begin
            rsp.page_code = shc_pkg::PageNoPower;
         end else if (entry_nxt.hot_fault) begin
            rsp.page_code = shc_pkg::PageHot;
         end else if (entry_nxt.cold_fault) begin
            rsp.page_code = shc_pkg::PageCold;
         end else begin
            rsp.health_state = shc_pkg::MainGood;
            rsp.page_code    = shc_pkg::PageGood;
         end

         if (rsp.health_state == shc_pkg::MainError) begin
            accum_nxt = 1'b1;
         end
      end

      rsp.alarm_any = accum_nxt;
   end

endmodule
`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the sensor health classifier
`timescale 1ns / 1ps
module tb;

   localparam int DevCount      = shc_pkg::DevicesDef;
   localparam int DeadLimit     = shc_pkg::DeadLimitDef;
   localparam int WatchdogLimit = 4000;
   localparam int ShownMax      = 10;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [shc_pkg::ReqDataW-1:0] req_tdata;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [shc_pkg::RspDataW-1:0] rsp_tdata;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [shc_pkg::CsrIdxW-1:0]  csr_index;
   logic [shc_pkg::WordW-1:0]    csr_data;

   // limit registers and per-device flags as the block should hold them
   shc_pkg::cfg_type           limits_m;
   logic [shc_pkg::CountW-1:0] dead_cnt_m [DevCount];
   logic                       link_flt_m [DevCount];
   logic                       gas_flt_m  [DevCount];
   logic                       hot_flt_m  [DevCount];
   logic                       cold_flt_m [DevCount];
   logic                       alarm_m;

   shc_pkg::rsp_type pending_results [$];
   int unsigned mismatch_cnt = 0;
   int unsigned stall_cycles = 0;
   int unsigned rdy_hold     = 0;
   bit          tx_free_run  = 1'b0;
   bit          rx_free_run  = 1'b0;

   sensor_health_classifier #(
      .DEVICES    (DevCount),
      .DEAD_LIMIT (DeadLimit)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // value close to a threshold, clamped to the word range
   function automatic logic [shc_pkg::WordW-1:0] near(input int center, input int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[shc_pkg::WordW-1:0];
   endfunction

   function automatic shc_pkg::req_type mk_report(input logic scan,
                                                  input logic [shc_pkg::DevW-1:0] dev,
                                                  input logic en,
                                                  input logic [shc_pkg::WordW-1:0] temp,
                                                  input logic [shc_pkg::WordW-1:0] co2,
                                                  input logic [shc_pkg::WordW-1:0] supply,
                                                  input logic [shc_pkg::WordW-1:0] raw);
      shc_pkg::req_type r;
      r.scan_start   = scan;
      r.device       = dev;
      r.enabled      = en;
      r.temperature  = temp;
      r.co2_level    = co2;
      r.supply_level = supply;
      r.rssi_raw     = raw;
      return r;
   endfunction

   // expected classification of one report, updates the device flags
   function automatic shc_pkg::rsp_type classify_report(input shc_pkg::req_type r);
      shc_pkg::rsp_type          res;
      logic [shc_pkg::WordW-1:0] strength;
      int unsigned               d;
      int                        temp_v, co2_v, gl, gb, hl, ll, tb_v;
      bit                        no_power;
      res = '0;
      if (r.scan_start) alarm_m = 1'b0;
      // a device index beyond the device count is handled as disabled
      if (r.enabled && (int'(r.device) < DevCount)) begin
         d        = int'(r.device);
         temp_v   = int'(r.temperature);
         co2_v    = int'(r.co2_level);
         gl       = int'(limits_m.gas_limit);
         gb       = int'(limits_m.gas_band);
         hl       = int'(limits_m.high_temp_limit);
         ll       = int'(limits_m.low_temp_limit);
         tb_v     = int'(limits_m.temp_band);
         strength = 16'hFFFF - r.rssi_raw;

         // link grading, exactly 100 still counts as good
         if (strength > shc_pkg::LinkDeadAbove) begin
            res.link_level   = shc_pkg::LinkDead;
            res.link_display = shc_pkg::LinkClamp;
         end else if (strength > shc_pkg::LinkWeakAbove) begin
            res.link_level   = shc_pkg::LinkWeak;
            res.link_display = strength[9:0];
         end else begin
            res.link_level   = shc_pkg::LinkGood;
            res.link_display = strength[9:0];
         end

         // dead-link counter saturates at the limit, then raises the fault
         if (res.link_level == shc_pkg::LinkDead) begin
            if (dead_cnt_m[d] < DeadLimit) dead_cnt_m[d] = dead_cnt_m[d] + 1'b1;
            else link_flt_m[d] = 1'b1;
         end else begin
            dead_cnt_m[d] = '0;
            link_flt_m[d] = 1'b0;
         end

         // hysteresis flags, thresholds never wrap
         if (gas_flt_m[d]) begin
            if (co2_v < gl - gb) gas_flt_m[d] = 1'b0;
         end else if (co2_v > gl + gb) gas_flt_m[d] = 1'b1;
         if (hot_flt_m[d]) begin
            if (temp_v < hl) hot_flt_m[d] = 1'b0;
         end else if (temp_v > hl + tb_v) hot_flt_m[d] = 1'b1;
         if (cold_flt_m[d]) begin
            if (temp_v > ll) cold_flt_m[d] = 1'b0;
         end else if (temp_v < ll - tb_v) cold_flt_m[d] = 1'b1;
         no_power = r.supply_level < limits_m.power_min;

         // page by fixed priority
         res.health_state = shc_pkg::MainError;
         if (link_flt_m[d]) res.page_code = shc_pkg::PageDead;
         else if (gas_flt_m[d]) res.page_code = shc_pkg::PageGas;
         else if (no_power) res.page_code = shc_pkg::PageNoPower;
         else if (hot_flt_m[d]) res.page_code = shc_pkg::PageHot;
         else if (cold_flt_m[d]) res.page_code = shc_pkg::PageCold;
         else begin
            res.health_state = shc_pkg::MainGood;
            res.page_code    = shc_pkg::PageGood;
         end
         if (res.health_state == shc_pkg::MainError) alarm_m = 1'b1;
      end
      res.alarm_any = alarm_m;
      return res;
   endfunction

   // one report beat, expectation recorded when accepted
   task automatic send_report(input shc_pkg::req_type r);
      int unsigned gap;
      gap = tx_free_run ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(shc_pkg::ReqDataW - $bits(shc_pkg::req_type)){1'b0}}, r};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(classify_report(r));
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // one register beat, valid left high for the next one
   task automatic write_reg(input logic [shc_pkg::CsrIdxW-1:0] idx,
                            input logic [shc_pkg::WordW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         shc_pkg::CsrGasLimit:  limits_m.gas_limit       = val;
         shc_pkg::CsrGasBand:   limits_m.gas_band        = val;
         shc_pkg::CsrHighLimit: limits_m.high_temp_limit = val;
         shc_pkg::CsrLowLimit:  limits_m.low_temp_limit  = val;
         shc_pkg::CsrTempBand:  limits_m.temp_band       = val;
         shc_pkg::CsrPowerMin:  limits_m.power_min       = val;
         default: ;
      endcase
   endtask

   // full limit set, only called with the block idle
   task automatic write_limits(input shc_pkg::cfg_type c);
      write_reg(shc_pkg::CsrGasLimit,  c.gas_limit);
      write_reg(shc_pkg::CsrGasBand,   c.gas_band);
      write_reg(shc_pkg::CsrHighLimit, c.high_temp_limit);
      write_reg(shc_pkg::CsrLowLimit,  c.low_temp_limit);
      write_reg(shc_pkg::CsrTempBand,  c.temp_band);
      write_reg(shc_pkg::CsrPowerMin,  c.power_min);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // random report aimed at thresholds of the current limits
   function automatic shc_pkg::req_type random_report(input logic [shc_pkg::DevW-1:0] dev,
                                                      input int unsigned dead_pct,
                                                      input bit first);
      shc_pkg::req_type          r;
      logic [shc_pkg::WordW-1:0] strength;
      int unsigned               pick;
      int                        gl, gb, hl, ll, tb_v;
      gl   = int'(limits_m.gas_limit);
      gb   = int'(limits_m.gas_band);
      hl   = int'(limits_m.high_temp_limit);
      ll   = int'(limits_m.low_temp_limit);
      tb_v = int'(limits_m.temp_band);
      // some plain noise
      if ($urandom_range(0, 9) == 0) begin
         r = shc_pkg::req_type'({$urandom, $urandom, $urandom});
         return r;
      end
      r.scan_start = first ? ($urandom_range(0, 99) < 40) : ($urandom_range(0, 99) < 5);
      r.device     = dev;
      r.enabled    = $urandom_range(0, 99) < 92;

      pick = $urandom_range(0, 99);
      if (pick < 25) r.temperature = near(hl + tb_v, 3);
      else if (pick < 40) r.temperature = near(hl, 3);
      else if (pick < 55) r.temperature = near(ll - tb_v, 3);
      else if (pick < 70) r.temperature = near(ll, 3);
      else if (pick < 80) r.temperature = near((hl + ll) / 2, 20);
      else r.temperature = 16'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 35) r.co2_level = near(gl + gb, 3);
      else if (pick < 70) r.co2_level = near(gl - gb, 3);
      else r.co2_level = 16'($urandom);

      r.supply_level = ($urandom_range(0, 99) < 40) ? near(int'(limits_m.power_min), 2)
                                                    : 16'($urandom);

      // link strength: dead, near a grade boundary, good or any raw word
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < dead_pct) begin
         strength = (pick < 70) ? 16'($urandom_range(201, 260))
                                : 16'($urandom_range(201, 65535));
         r.rssi_raw = 16'hFFFF - strength;
      end else if (pick < 40) r.rssi_raw = 16'hFFFF - near(100, 2);
      else if (pick < 60) r.rssi_raw = 16'hFFFF - near(200, 2);
      else if (pick < 85) r.rssi_raw = 16'hFFFF - 16'($urandom_range(0, 100));
      else r.rssi_raw = 16'($urandom);
      return r;
   endfunction

   // runs of reports to one device, with stray reports to others
   task automatic run_sequences(input int unsigned n_items);
      int unsigned sent, since_drain, len, dead_pct, k;
      logic [shc_pkg::DevW-1:0] dev, d;
      sent        = 0;
      since_drain = 0;
      while (sent < n_items) begin
         dev = shc_pkg::DevW'($urandom);
         len = $urandom_range(1, 16);
         case ($urandom_range(0, 2))
            0: dead_pct = 0;
            1: dead_pct = 50;
            default: dead_pct = 95;
         endcase
         for (k = 0; k < len; k++) begin
            d = ($urandom_range(0, 4) == 0) ? shc_pkg::DevW'($urandom) : dev;
            send_report(random_report(d, dead_pct, k == 0));
            sent++;
            since_drain++;
         end
         // hold off now and then until the block has emptied
         if (since_drain >= 150) begin
            drain_results();
            since_drain = 0;
         end
      end
      drain_results();
   endtask

   // grading boundaries, field extremes and each hysteresis edge at default limits
   task automatic test_directed_defaults();
      send_report(mk_report(1'b1, 4'd0,  1'b1, 16'd200,   16'd500,   16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd0,  1'b1, 16'd200,   16'd500,   16'd1000,  16'hFF9B));
      send_report(mk_report(1'b0, 4'd0,  1'b1, 16'd200,   16'd500,   16'd1000,  16'hFF9A));
      send_report(mk_report(1'b0, 4'd0,  1'b1, 16'd200,   16'd500,   16'd1000,  16'hFF37));
      send_report(mk_report(1'b0, 4'd1,  1'b1, 16'd200,   16'd500,   16'd1000,  16'hFF36));
      send_report(mk_report(1'b0, 4'd15, 1'b1, 16'd0,     16'd0,     16'hFFFF,  16'h0000));
      send_report(mk_report(1'b1, 4'd2,  1'b0, 16'hFFFF,  16'hFFFF,  16'h0000,  16'h0000));
      send_report(mk_report(1'b0, 4'd3,  1'b1, 16'd200,   16'd500,   16'd0,     16'hFFFF));
      send_report(mk_report(1'b0, 4'd3,  1'b1, 16'd200,   16'd500,   16'd671,   16'hFFFF));
      send_report(mk_report(1'b0, 4'd3,  1'b1, 16'd200,   16'd500,   16'd672,   16'hFFFF));
      // high temperature set, held inside the band, released
      send_report(mk_report(1'b0, 4'd4,  1'b1, 16'd360,   16'd500,   16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd4,  1'b1, 16'd361,   16'd500,   16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd4,  1'b1, 16'd350,   16'd500,   16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd4,  1'b1, 16'd349,   16'd500,   16'd1000,  16'hFFFF));
      // low temperature set, held, released
      send_report(mk_report(1'b0, 4'd6,  1'b1, 16'd89,    16'd500,   16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd6,  1'b1, 16'd100,   16'd500,   16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd6,  1'b1, 16'd101,   16'd500,   16'd1000,  16'hFFFF));
      // gas set, held, released, then the top of the range
      send_report(mk_report(1'b0, 4'd7,  1'b1, 16'd200,   16'd1051,  16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd7,  1'b1, 16'd200,   16'd950,   16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd7,  1'b1, 16'd200,   16'd949,   16'd1000,  16'hFFFF));
      send_report(mk_report(1'b0, 4'd8,  1'b1, 16'hFFFF,  16'hFFFF,  16'd1000,  16'hFFFF));
      drain_results();
   endtask

   // dead-link counter runs up to the limit, the next dead report faults, good clears
   task automatic test_dead_link();
      int unsigned k;
      for (k = 0; k <= DeadLimit; k++)
         send_report(mk_report(k == 0, 4'd5, 1'b1, 16'd200, 16'd2000, 16'd1000, 16'hFF00));
      send_report(mk_report(1'b0, 4'd5, 1'b1, 16'd200, 16'd2000, 16'd1000, 16'hFFF0));
      drain_results();
   endtask

   // extreme limit settings, including thresholds pushed below zero or past the word
   task automatic test_limit_extremes();
      shc_pkg::cfg_type c;
      c = '0;
      write_limits(c);
      run_sequences(60);
      c = '1;
      write_limits(c);
      run_sequences(60);
      c = '{gas_limit: 16'h0000, gas_band: 16'hFFFF, high_temp_limit: 16'hFFFF,
            low_temp_limit: 16'h0000, temp_band: 16'hFFFF, power_min: 16'hFFFF};
      write_limits(c);
      run_sequences(60);
      c = '{gas_limit: 16'hFFFF, gas_band: 16'h0000, high_temp_limit: 16'h0000,
            low_temp_limit: 16'hFFFF, temp_band: 16'h0000, power_min: 16'h0000};
      write_limits(c);
      run_sequences(60);
   endtask

   // random limit sets, one phase without any idling, defaults restored at the end
   task automatic test_random_limits();
      shc_pkg::cfg_type c;
      int unsigned      ph;
      for (ph = 0; ph < 5; ph++) begin
         if ($urandom_range(0, 1)) begin
            c = shc_pkg::cfg_type'({$urandom, $urandom, $urandom});
         end else begin
            c.gas_limit       = 16'($urandom_range(200, 3000));
            c.gas_band        = 16'($urandom_range(0, 200));
            c.high_temp_limit = 16'($urandom_range(200, 600));
            c.low_temp_limit  = 16'($urandom_range(0, 200));
            c.temp_band       = 16'($urandom_range(0, 40));
            c.power_min       = 16'($urandom_range(300, 1000));
         end
         write_limits(c);
         tx_free_run = (ph == 2);
         rx_free_run = (ph == 2);
         run_sequences(90);
      end
      tx_free_run = 1'b0;
      rx_free_run = 1'b0;
      c = '{gas_limit: shc_pkg::GasLimitRst, gas_band: shc_pkg::GasBandRst,
            high_temp_limit: shc_pkg::HighLimitRst, low_temp_limit: shc_pkg::LowLimitRst,
            temp_band: shc_pkg::TempBandRst, power_min: shc_pkg::PowerMinRst};
      write_limits(c);
      run_sequences(90);
   endtask

   // result side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rdy_hold   <= 0;
      end else if (rdy_hold != 0) begin
         rdy_hold <= rdy_hold - 1;
      end else if (rx_free_run) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 1)) begin
         rsp_tready <= 1'b1;
         rdy_hold   <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b0;
         rdy_hold   <= pick_gap();
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      shc_pkg::rsp_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = shc_pkg::rsp_type'(rsp_tdata[$bits(shc_pkg::rsp_type)-1:0]);
         if (pending_results.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ShownMax)
               $display("unexpected result: main %0d page %0d level %0d disp %0d alarm %0d",
                        got.health_state, got.page_code, got.link_level,
                        got.link_display, got.alarm_any);
         end else begin
            exp_r = pending_results.pop_front();
            if (got.health_state !== exp_r.health_state || got.page_code !== exp_r.page_code
                || got.link_level !== exp_r.link_level
                || got.link_display !== exp_r.link_display
                || got.alarm_any !== exp_r.alarm_any) begin
               mismatch_cnt++;
               if (mismatch_cnt <= ShownMax)
                  $display("mismatch: exp main %0d page %0d level %0d disp %0d alarm %0d, %s",
                           exp_r.health_state, exp_r.page_code, exp_r.link_level,
                           exp_r.link_display, exp_r.alarm_any,
                           $sformatf("got main %0d page %0d level %0d disp %0d alarm %0d",
                                     got.health_state, got.page_code, got.link_level,
                                     got.link_display, got.alarm_any));
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("[sensor_health_classifier] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // test sequence
   initial begin
      limits_m = '{gas_limit: shc_pkg::GasLimitRst, gas_band: shc_pkg::GasBandRst,
                   high_temp_limit: shc_pkg::HighLimitRst,
                   low_temp_limit: shc_pkg::LowLimitRst,
                   temp_band: shc_pkg::TempBandRst, power_min: shc_pkg::PowerMinRst};
      for (int i = 0; i < DevCount; i++) begin
         dead_cnt_m[i] = '0;
         link_flt_m[i] = 1'b0;
         gas_flt_m[i]  = 1'b0;
         hot_flt_m[i]  = 1'b0;
         cold_flt_m[i] = 1'b0;
      end
      alarm_m    = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_dead_link();
      test_limit_extremes();
      test_random_limits();

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_cnt == 0 && pending_results.size() == 0)
         $display("[sensor_health_classifier] OK");
      else
         $display("[sensor_health_classifier] ERROR");
      $finish;
   end

endmodule
